// ===== rtl/core/rda_pkg.sv =====
// Shared constants and beat types for the radial dead zone axis block.
package rda_pkg;

    // Pipeline depths, one bit step per stage
    localparam int SQRT_LAT       = 28;                 // 56-bit radicand, 28 root bits
    localparam int FDIV_LAT       = 49;                 // direction fraction, Q48 quotient
    localparam int AXIS_FRAC_BITS = 15;
    localparam int TDIV_LAT       = 16;                 // magnitude / travel radius
    localparam int KDIV_LAT       = AXIS_FRAC_BITS + 1; // rescale quotient bits
    localparam int MAG_LAT        = SQRT_LAT + TDIV_LAT + 1 + KDIV_LAT;
    localparam int AXIS_LAT       = FDIV_LAT + SQRT_LAT;
    localparam int KDLY           = AXIS_LAT - MAG_LAT;

    localparam logic [15:0] AXIS_SAT       = 16'd32767;
    localparam logic [11:0] PAD_RADIUS_RST = 12'd50;
    localparam logic [15:0] DEAD_ZONE_RST  = 16'd7864;

    // Register index (word address bit 2)
    localparam logic REG_PAD_RADIUS = 1'b0;
    localparam logic REG_DEAD_ZONE  = 1'b1;

    typedef struct packed {
        logic               pressed;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_rda_in;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
    } t_rda_out;

endpackage

// ===== rtl/core/rda_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rda_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [55:0] i_rad,
    output logic        o_valid,
    output logic [27:0] o_root
);
    import rda_pkg::*;

    typedef struct packed {
        logic [55:0] rad;
        logic [31:0] rem;
        logic [27:0] root;
    } t_sq_st;

    function automatic t_sq_st sq_step(input t_sq_st a);
        logic [31:0] rem2;
        logic [31:0] trial;
        t_sq_st      o;
        rem2  = {a.rem[29:0], a.rad[55:54]};
        trial = {2'b00, a.root, 2'b01};
        o.rad = {a.rad[53:0], 2'b00};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {a.root[26:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {a.root[26:0], 1'b0};
        end
        return o;
    endfunction

    t_sq_st              r_st [SQRT_LAT];
    logic [SQRT_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQRT_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= sq_step(t_sq_st'{rad: i_rad, rem: 32'd0, root: 28'd0});
        for (int s = 1; s < SQRT_LAT; s++) begin
            r_st[s] <= sq_step(r_st[s-1]);
        end
    end

    assign o_valid = r_vld[SQRT_LAT-1];
    assign o_root  = r_st[SQRT_LAT-1].root;

endmodule

// ===== rtl/core/rda_fdiv.sv =====
// Pipelined fraction divider: floor(num * 2^48 / den) for num <= den.
module rda_fdiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_valid,
    output logic [48:0] o_quo
);
    import rda_pkg::*;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] den;
        logic [48:0] q;
    } t_fd_st;

    function automatic t_fd_st fd_first(input logic [31:0] num, input logic [31:0] den);
        logic   ge;
        t_fd_st o;
        ge    = (num >= den);
        o.r   = ge ? (num - den) : num;
        o.den = den;
        o.q   = {48'd0, ge};
        return o;
    endfunction

    function automatic t_fd_st fd_step(input t_fd_st a);
        logic [32:0] r2;
        logic [32:0] d2;
        logic [32:0] diff;
        logic        ge;
        t_fd_st      o;
        r2    = {a.r, 1'b0};
        d2    = {1'b0, a.den};
        diff  = r2 - d2;
        ge    = (r2 >= d2);
        o.r   = ge ? diff[31:0] : r2[31:0];
        o.den = a.den;
        o.q   = {a.q[47:0], ge};
        return o;
    endfunction

    t_fd_st              r_st [FDIV_LAT];
    logic [FDIV_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FDIV_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= fd_first(i_num, i_den);
        for (int s = 1; s < FDIV_LAT; s++) begin
            r_st[s] <= fd_step(r_st[s-1]);
        end
    end

    assign o_valid = r_vld[FDIV_LAT-1];
    assign o_quo   = r_st[FDIV_LAT-1].q;

endmodule

// ===== rtl/core/rda_mag.sv =====
// Magnitude path: sqrt, divide by travel radius, dead zone test, rescale gain.
module rda_mag (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_s,
    input  logic [11:0] i_t,
    input  logic [23:0] i_tt,
    input  logic [15:0] i_dz,
    output logic        o_valid,
    output logic [15:0] o_k,
    output logic        o_dead
);
    import rda_pkg::*;

    localparam int POST_LAT = MAG_LAT - SQRT_LAT;

    typedef struct packed {
        logic [12:0] rem;
        logic [15:0] low;
        logic [15:0] q;
        logic        outside;
    } t_td_st;

    typedef struct packed {
        logic [16:0] r;
        logic [15:0] k;
        logic        dead;
    } t_k_st;

    function automatic t_td_st td_step(input t_td_st a, input logic [11:0] t);
        logic [12:0] rem2;
        logic [12:0] diff;
        logic        ge;
        t_td_st      o;
        rem2      = {a.rem[11:0], a.low[15]};
        diff      = rem2 - {1'b0, t};
        ge        = (rem2 >= {1'b0, t});
        o.rem     = ge ? diff : rem2;
        o.low     = {a.low[14:0], 1'b0};
        o.q       = {a.q[14:0], ge};
        o.outside = a.outside;
        return o;
    endfunction

    function automatic t_k_st k_first(input logic [16:0] n, input logic [16:0] den,
                                      input logic dead);
        logic  ge;
        t_k_st o;
        ge     = (n >= den);
        o.r    = ge ? (n - den) : n;
        o.k    = {15'd0, ge};
        o.dead = dead;
        return o;
    endfunction

    function automatic t_k_st k_step(input t_k_st a, input logic [16:0] den);
        logic [17:0] r2;
        logic [17:0] d2;
        logic [17:0] diff;
        logic        ge;
        t_k_st       o;
        r2     = {a.r, 1'b0};
        d2     = {1'b0, den};
        diff   = r2 - d2;
        ge     = (r2 >= d2);
        o.r    = ge ? diff[16:0] : r2[16:0];
        o.k    = {a.k[14:0], ge};
        o.dead = a.dead;
        return o;
    endfunction

    logic                w_sq_vld;
    logic [27:0]         w_root;
    logic [SQRT_LAT-1:0] r_out_dly;
    logic [POST_LAT-1:0] r_vld;
    t_td_st              r_td [TDIV_LAT];
    t_k_st               r_k  [KDIV_LAT];
    logic [16:0]         r_c1_n;
    logic                r_c1_dead;
    logic [16:0]         w_den;
    logic [16:0]         w_c;
    t_td_st              w_td_last;

    // Only inside travel (s < T*T < 2^24) does the root matter
    rda_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_rad   ({i_s[23:0], 32'd0}),
        .o_valid (w_sq_vld),
        .o_root  (w_root)
    );

    assign w_den     = 17'h10000 - {1'b0, i_dz};
    assign w_td_last = r_td[TDIV_LAT-1];
    assign w_c       = w_td_last.outside ? 17'h10000 : {1'b0, w_td_last.q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[POST_LAT-2:0], w_sq_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dly <= {r_out_dly[SQRT_LAT-2:0], (i_s >= {8'd0, i_tt})};
        r_td[0]   <= td_step(t_td_st'{rem: {1'b0, w_root[27:16]}, low: w_root[15:0],
                                      q: 16'd0, outside: r_out_dly[SQRT_LAT-1]}, i_t);
        for (int s = 1; s < TDIV_LAT; s++) begin
            r_td[s] <= td_step(r_td[s-1], i_t);
        end
        r_c1_n    <= w_c - {1'b0, i_dz};
        r_c1_dead <= !w_td_last.outside && (w_td_last.q <= i_dz);
        r_k[0]    <= k_first(r_c1_n, w_den, r_c1_dead);
        for (int s = 1; s < KDIV_LAT; s++) begin
            r_k[s] <= k_step(r_k[s-1], w_den);
        end
    end

    assign o_valid = r_vld[POST_LAT-1];
    assign o_k     = r_k[KDIV_LAT-1].k;
    assign o_dead  = r_k[KDIV_LAT-1].dead;

endmodule

// ===== rtl/core/radial_deadzone_axes.sv =====
// Top level: stick position to dead-zoned Q1.15 axis pair, fully pipelined.
//
//  channel   ports                                   beat taken when
//  --------  --------------------------------------  -------------------------
//  command   start, busy, i_cmd                      start && !busy
//  result    o_result_valid, o_result                o_result_valid (1 cycle)
//  config    psel penable pwrite paddr pwdata        psel&&penable&&pwrite
//            prdata pready                           (pready tied high)
//
// One command beat per cycle, every cycle; busy is never raised.
// The pipeline has 4 front stages (offset, abs, squares, sum), then the
// direction fraction divider (49 bit steps) feeding a square root (28 bit
// steps), then 2 stages for the gain multiply and saturation. The magnitude
// and gain path runs in parallel and is delay-matched to the direction path.
// Reset is synchronous, active low; it clears valid bits and the registers
// (pad_radius 50, dead_zone_q16 7864). There is no clearing pass. The result
// side cannot stall, so nothing in the pipeline ever holds.
module radial_deadzone_axes (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rda_pkg::t_rda_in  i_cmd,
    output logic              o_result_valid,
    output rda_pkg::t_rda_out o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rda_pkg::*;

    typedef struct packed {
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_side;

    typedef struct packed {
        logic [15:0] k;
        logic        dead;
    } t_kd;

    // ---------------- configuration ----------------
    logic [11:0] r_pad;
    logic [15:0] r_dz;
    logic [11:0] r_t;
    logic [23:0] r_tt;
    logic [11:0] n_t;
    logic [11:0] w_t_raw;
    logic        w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= PAD_RADIUS_RST;
            r_dz  <= DEAD_ZONE_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_PAD_RADIUS: r_pad <= pwdata[11:0];
                REG_DEAD_ZONE:  r_dz  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PAD_RADIUS: prdata = {20'd0, r_pad};
            REG_DEAD_ZONE:  prdata = {16'd0, r_dz};
            default:        prdata = 32'd0;
        endcase
    end

    // travel radius T = max(1, R - R/4) and T*T, static between writes
    assign w_t_raw = r_pad - {2'b00, r_pad[11:2]};
    assign n_t     = (w_t_raw == 12'd0) ? 12'd1 : w_t_raw;

    always_ff @(posedge i_clk) begin
        r_t  <= n_t;
        r_tt <= {12'd0, r_t} * {12'd0, r_t};
    end

    // ---------------- front stages ----------------
    logic        r1_vld, r2_vld, r3_vld, r4_vld;
    logic [17:0] r1_dx, r1_dy;
    logic        r1_zero;
    logic [15:0] r2_ax, r2_ay;
    t_side       r2_side, r3_side, r4_side;
    logic [31:0] r3_sqx, r3_sqy;
    logic [31:0] r4_sqx, r4_sqy, r4_s;
    logic [17:0] w_dx, w_dy, w_ax, w_ay;

    // dx = x - R, dy = R - y (Y up)
    assign w_dx = {{2{i_cmd.pos_x[15]}}, i_cmd.pos_x} - {6'd0, r_pad};
    assign w_dy = {6'd0, r_pad} - {{2{i_cmd.pos_y[15]}}, i_cmd.pos_y};
    assign w_ax = r1_dx[17] ? (18'd0 - r1_dx) : r1_dx;
    assign w_ay = r1_dy[17] ? (18'd0 - r1_dy) : r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= start & !busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx   <= w_dx;
        r1_dy   <= w_dy;
        r1_zero <= !i_cmd.pressed || (r_pad == 12'd0);
        r2_ax   <= w_ax[15:0];
        r2_ay   <= w_ay[15:0];
        r2_side <= t_side'{zero: r1_zero, neg_x: r1_dx[17], neg_y: r1_dy[17]};
        r3_sqx  <= {16'd0, r2_ax} * {16'd0, r2_ax};
        r3_sqy  <= {16'd0, r2_ay} * {16'd0, r2_ay};
        r3_side <= r2_side;
        r4_s    <= r3_sqx + r3_sqy;
        r4_sqx  <= r3_sqx;
        r4_sqy  <= r3_sqy;
        r4_side <= r3_side;
    end

    // ---------------- direction path: sqrt(a^2 * 2^48 / s) ----------------
    logic        w_fx_vld, w_fy_vld, w_ux_vld, w_uy_vld;
    logic [48:0] w_fx_q, w_fy_q;
    logic [27:0] w_ux, w_uy;

    rda_fdiv u_fdiv_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .i_num   (r4_sqx),
        .i_den   (r4_s),
        .o_valid (w_fx_vld),
        .o_quo   (w_fx_q)
    );

    rda_fdiv u_fdiv_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .i_num   (r4_sqy),
        .i_den   (r4_s),
        .o_valid (w_fy_vld),
        .o_quo   (w_fy_q)
    );

    rda_sqrt u_sqrt_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fx_vld),
        .i_rad   ({7'd0, w_fx_q}),
        .o_valid (w_ux_vld),
        .o_root  (w_ux)
    );

    rda_sqrt u_sqrt_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fy_vld),
        .i_rad   ({7'd0, w_fy_q}),
        .o_valid (w_uy_vld),
        .o_root  (w_uy)
    );

    // ---------------- magnitude path: dead zone and gain k ----------------
    logic        w_mag_vld;
    logic [15:0] w_k;
    logic        w_dead;

    rda_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .i_s     (r4_s),
        .i_t     (r_t),
        .i_tt    (r_tt),
        .i_dz    (r_dz),
        .o_valid (w_mag_vld),
        .o_k     (w_k),
        .o_dead  (w_dead)
    );

    // ---------------- alignment delays ----------------
    t_side           r_side [AXIS_LAT];
    t_kd             r_kd   [KDLY];
    logic [KDLY-1:0] r_kv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv <= '0;
        end else begin
            r_kv <= {r_kv[KDLY-2:0], w_mag_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= r4_side;
        for (int s = 1; s < AXIS_LAT; s++) begin
            r_side[s] <= r_side[s-1];
        end
        r_kd[0] <= t_kd'{k: w_k, dead: w_dead};
        for (int s = 1; s < KDLY; s++) begin
            r_kd[s] <= r_kd[s-1];
        end
    end

    // ---------------- gain multiply and output ----------------
    logic        r5_vld;
    logic [40:0] r5_px, r5_py;
    logic        r5_zero, r5_negx, r5_negy;
    t_rda_out    r_res;
    logic        r_res_vld;
    logic [16:0] w_mx, w_my;
    logic [15:0] w_sx, w_sy;
    logic [15:0] n_axis_x, n_axis_y;

    // |axis| = (u * k) >> 24, clipped to full scale
    assign w_mx     = r5_px[40:24];
    assign w_my     = r5_py[40:24];
    assign w_sx     = (w_mx > {1'b0, AXIS_SAT}) ? AXIS_SAT : w_mx[15:0];
    assign w_sy     = (w_my > {1'b0, AXIS_SAT}) ? AXIS_SAT : w_my[15:0];
    assign n_axis_x = r5_zero ? 16'd0 : (r5_negx ? (16'd0 - w_sx) : w_sx);
    assign n_axis_y = r5_zero ? 16'd0 : (r5_negy ? (16'd0 - w_sy) : w_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld    <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r5_vld    <= w_ux_vld & w_uy_vld & r_kv[KDLY-1];
            r_res_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_px        <= {16'd0, w_ux[24:0]} * {25'd0, r_kd[KDLY-1].k};
        r5_py        <= {16'd0, w_uy[24:0]} * {25'd0, r_kd[KDLY-1].k};
        r5_zero      <= r_side[AXIS_LAT-1].zero | r_kd[KDLY-1].dead;
        r5_negx      <= r_side[AXIS_LAT-1].neg_x;
        r5_negy      <= r_side[AXIS_LAT-1].neg_y;
        r_res.axis_x <= n_axis_x;
        r_res.axis_y <= n_axis_y;
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

endmodule
